// ----- hdl/gcs_pkg.sv -----
// ============================================================================
// gcs_pkg - gait contact scheduler shared types
// Beat layouts for the request and result channels, register indexes.
// ============================================================================
`default_nettype none

package gcs_pkg;

    localparam int PHASE_W = 8;
    localparam int LEGS    = 4;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_OFFSETS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_DURATIONS  = 2'd3;

    // request modes
    localparam logic OP_FULL   = 1'b0;
    localparam logic OP_CHANGE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] gait_iteration;
    } gcs_in_t;

    typedef struct packed {
        logic [3:0] step_index;
        logic [3:0] contact_mask;
        logic       update;
        logic       last;
    } gcs_out_t;

endpackage

`default_nettype wire

// ----- hdl/gcs_leg_lanes.sv -----
// ============================================================================
// gcs_leg_lanes - per-leg stance test
// Four lanes; each compares the leg's progress through the cycle with its
// stance duration for one phase value.
// ============================================================================
`default_nettype none

module gcs_leg_lanes (
    input  wire logic [gcs_pkg::PHASE_W-1:0]          phase,
    input  wire logic [gcs_pkg::PHASE_W-1:0]          period,
    input  wire logic [gcs_pkg::LEGS*gcs_pkg::PHASE_W-1:0] offsets,
    input  wire logic [gcs_pkg::LEGS*gcs_pkg::PHASE_W-1:0] durations,
    output logic      [gcs_pkg::LEGS-1:0]             mask
);

    localparam int W = gcs_pkg::PHASE_W;

    always_comb
    begin
        logic [W-1:0] off;
        logic [W-1:0] dur;
        logic [W:0]   base;
        logic [W:0]   lim;
        for (int leg = 0; leg < gcs_pkg::LEGS; leg++)
        begin
            off = offsets[leg*W +: W];
            dur = durations[leg*W +: W];
            // phase - off wraps once by the period; a result still negative
            // counts as in stance, which base < off + dur also gives
            base = (phase < off) ? ({1'b0, phase} + {1'b0, period}) : {1'b0, phase};
            lim  = {1'b0, off} + {1'b0, dur};
            mask[leg] = (base < lim);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/legged_gait_contact_scheduler.sv -----
// ============================================================================
// legged_gait_contact_scheduler - four-leg contact mask sequencer
// Emits one contact mask beat per horizon step for each request.
// ============================================================================
// A request first reduces gait_iteration modulo cycle_period in a bit-serial
// restoring remainder unit, then emits one horizon step per cycle while the
// output register is free. in_ready is high only between requests; the last
// result beat may still be waiting in the output register when the next
// request is taken. Registers must be written only while no request is in
// work; the block itself does not enforce this.
`default_nettype none

module legged_gait_contact_scheduler #(
    parameter int HORIZON_MAX = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [gcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gcs_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire gcs_pkg::gcs_in_t                in_beat,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output gcs_pkg::gcs_out_t                    out_beat
);

    localparam int W     = gcs_pkg::PHASE_W;
    localparam int SW    = $clog2(HORIZON_MAX + 1);
    localparam int POS_W = $clog2(256 + HORIZON_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;

    // configuration
    logic [W-1:0]  period_reg;
    logic [4:0]    horizon_reg;
    logic [31:0]   offsets_reg;
    logic [31:0]   durations_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= 8'd10;
            horizon_reg   <= 5'd10;
            offsets_reg   <= '0;
            durations_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gcs_pkg::CFG_CYCLE_PERIOD:   period_reg    <= cfg_data[W-1:0];
                gcs_pkg::CFG_HORIZON_LENGTH: horizon_reg   <= cfg_data[4:0];
                gcs_pkg::CFG_LEG_OFFSETS:    offsets_reg   <= cfg_data;
                gcs_pkg::CFG_LEG_DURATIONS:  durations_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [W-1:0]  period_eff;
    logic [SW-1:0] horizon_eff;

    assign period_eff = (period_reg == '0) ? W'(1) : period_reg;

    always_comb
    begin
        if (horizon_reg == 5'd0)
            horizon_eff = SW'(1);
        else if (int'(horizon_reg) > HORIZON_MAX)
            horizon_eff = SW'(HORIZON_MAX);
        else
            horizon_eff = SW'(horizon_reg);
    end

    // sequencer
    logic [1:0]       state_reg, state_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [W-1:0]     shift_reg, shift_next;     // dividend bits, msb first
    logic [W-1:0]     phase_reg, phase_next;     // remainder, then running phase
    logic [POS_W-1:0] pos_reg, pos_next;         // gait_iteration + step
    logic [SW-1:0]    step_reg, step_next;
    logic             op_reg, op_next;
    logic             out_valid_reg, out_valid_next;
    gcs_pkg::gcs_out_t out_reg, out_next;

    logic [W:0]           trial;
    logic [W:0]           phase_inc;
    logic [gcs_pkg::LEGS-1:0] lane_mask;
    logic                 slot_free;
    logic                 upd;
    logic                 is_last;
    logic [SW+3:0]        step_ext;

    gcs_leg_lanes u_lanes (
        .phase     (phase_reg),
        .period    (period_eff),
        .offsets   (offsets_reg),
        .durations (durations_reg),
        .mask      (lane_mask)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign trial     = {phase_reg, shift_reg[W-1]};
    assign phase_inc = {1'b0, phase_reg} + (W+1)'(1);
    assign upd       = (op_reg == gcs_pkg::OP_FULL) ||
                       (pos_reg >= POS_W'(period_eff));
    assign is_last   = (step_reg == horizon_eff - SW'(1));
    assign step_ext  = {4'b0, step_reg};

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = in_beat.op;
                    shift_next   = in_beat.gait_iteration;
                    pos_next     = POS_W'(in_beat.gait_iteration);
                    phase_next   = '0;
                    bit_cnt_next = '0;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one restoring remainder step per cycle
                if (trial >= {1'b0, period_eff})
                    phase_next = W'(trial - {1'b0, period_eff});
                else
                    phase_next = trial[W-1:0];
                shift_next   = {shift_reg[W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.step_index   = step_ext[3:0];
                    out_next.contact_mask = upd ? lane_mask : '0;
                    out_next.update       = upd;
                    out_next.last         = is_last;
                    phase_next = (phase_inc == {1'b0, period_eff}) ? '0 : phase_inc[W-1:0];
                    pos_next   = pos_reg + POS_W'(1);
                    step_next  = step_reg + SW'(1);
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        shift_reg   <= shift_next;
        phase_reg   <= phase_next;
        pos_reg     <= pos_next;
        step_reg    <= step_next;
        op_reg      <= op_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

// ----- hdl/gcs_checker.sv -----
// ============================================================================
// gcs_checker - port-level checks for the contact scheduler
// Watches the request and result channels; bound to the top level.
// ============================================================================
`default_nettype none

module gcs_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire gcs_pkg::gcs_out_t out_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result beat changed while stalled");

    // a taken request keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a request");

    // no new request while the horizon is still being emitted
    a_busy_mid_horizon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.last |-> !in_ready)
        else $error("ready while a non-final beat is pending");

    // entries not flagged carry no contacts
    a_mask_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.update |-> out_beat.contact_mask == 4'd0)
        else $error("contact mask set on an entry not flagged for update");

endmodule

bind legged_gait_contact_scheduler gcs_checker u_gcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
);

`default_nettype wire
